// ===== hw/rtl/gwc_pkg.sv =====
// gwc_pkg: widths, constants and calendar tables for the gps week to date converter
// no dependencies; used by the interfaces and every module of the block
package gwc_pkg;

  localparam int unsigned WeekW   = 13;
  localparam int unsigned SecsW   = 20;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned WdW     = 3;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;

  // pipeline depth, one enable per register stage
  localparam int unsigned NumStages = 5;

  localparam logic [SecsW-1:0] SecsPerWeek = 20'd604800;
  localparam logic [16:0]      SecsPerDay  = 17'd86400;
  localparam logic [11:0]      SecsPerHour = 12'd3600;
  localparam logic [5:0]       SecsPerMin  = 6'd60;

  // floor(x / d) == (x * Recip) >> Shift over the value range of each stage
  localparam logic [17:0]      HourRecip = 18'd149131;
  localparam int unsigned      HourShift = 29;
  localparam logic [11:0]      MinRecip  = 12'd2185;
  localparam int unsigned      MinShift  = 17;
  localparam logic [15:0]      BlkRecip  = 16'd45934;
  localparam int unsigned      BlkShift  = 26;

  localparam logic [10:0]      DaysPerBlock = 11'd1461;
  localparam logic [YearW-1:0] EpochYear    = 12'd1980;
  localparam logic [3:0]       DaysPerWeek  = 4'd7;
  localparam logic [5:0]       EpochDay     = 6'd6;
  localparam logic [MonthW-1:0] LastMonth   = 4'd11;
  localparam logic [MonthW-1:0] MonthWrap   = 4'd12;

  // first day offset of each year inside a four-year block, leap year first
  localparam logic [10:0] BlockStart [4] = '{11'd0, 11'd366, 11'd731, 11'd1096};

  localparam logic [8:0] CumNormal [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
  localparam logic [8:0] CumLeap [13] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

endpackage

// ===== hw/rtl/gwc_if.sv =====
// gwc_in_if and gwc_out_if: valid/ready channels of the gps week to date converter
// depends on gwc_pkg for the field widths
interface gwc_in_if;
  logic                         valid;
  logic                         ready;
  logic [gwc_pkg::WeekW-1:0]    gps_week;
  logic [gwc_pkg::SecsW-1:0]    seconds_of_week;

  modport source (output valid, output gps_week, output seconds_of_week, input ready);
  modport sink   (input valid, input gps_week, input seconds_of_week, output ready);
endinterface

interface gwc_out_if;
  logic                         valid;
  logic                         ready;
  logic [gwc_pkg::YearW-1:0]    year;
  logic [gwc_pkg::MonthW-1:0]   month_index;
  logic [gwc_pkg::DayW-1:0]     day_of_month;
  logic [gwc_pkg::WdW-1:0]      weekday;
  logic [gwc_pkg::HourW-1:0]    hour_of_day;
  logic [gwc_pkg::MinW-1:0]     minute_of_hour;
  logic [gwc_pkg::SecW-1:0]     second_of_minute;

  modport source (output valid, output year, output month_index, output day_of_month,
                  output weekday, output hour_of_day, output minute_of_hour,
                  output second_of_minute, input ready);
  modport sink   (input valid, input year, input month_index, input day_of_month,
                  input weekday, input hour_of_day, input minute_of_hour,
                  input second_of_minute, output ready);
endinterface

// ===== hw/rtl/gwc_tod_pipe.sv =====
// gwc_tod_pipe: five-stage split of seconds of week into weekday, hour, minute, second
// depends on gwc_pkg; stage enables come from the top level
module gwc_tod_pipe (
  input  logic                            clk_i,
  input  logic [gwc_pkg::NumStages-1:0]   en_i,
  input  logic [gwc_pkg::SecsW-1:0]       secs_i,
  output logic [gwc_pkg::WdW-1:0]         wd_s4_o,
  output logic [gwc_pkg::WdW-1:0]         weekday_o,
  output logic [gwc_pkg::HourW-1:0]       hour_o,
  output logic [gwc_pkg::MinW-1:0]        minute_o,
  output logic [gwc_pkg::SecW-1:0]        second_o
);

  logic [gwc_pkg::SecsW-1:0] sat;
  logic [gwc_pkg::WdW-1:0]   wd_d;
  logic [16:0]               rem_day_d;
  logic [34:0]               hr_prod;
  logic [gwc_pkg::HourW-1:0] hr_d;
  logic [11:0]               rem_hr_d;
  logic [23:0]               mn_prod;
  logic [gwc_pkg::MinW-1:0]  mn_d;
  logic [gwc_pkg::SecW-1:0]  sc_d;

  logic [gwc_pkg::WdW-1:0]   wd_q1, wd_q2, wd_q3, wd_q4, wd_q5;
  logic [16:0]               rem_day_q1, rem_day_q2;
  logic [gwc_pkg::HourW-1:0] hr_q2, hr_q3, hr_q4, hr_q5;
  logic [11:0]               rem_hr_q3, rem_hr_q4;
  logic [gwc_pkg::MinW-1:0]  mn_q4, mn_q5;
  logic [gwc_pkg::SecW-1:0]  sc_q5;

  // stage 1: saturate, weekday by threshold compare, seconds into the day
  always_comb begin
    sat = (secs_i >= gwc_pkg::SecsPerWeek) ? (gwc_pkg::SecsPerWeek - 20'd1) : secs_i;
    wd_d = '0;
    for (int k = 1; k < 7; k++) begin
      if (sat >= 20'(k) * 20'(gwc_pkg::SecsPerDay)) begin
        wd_d = 3'(k);
      end
    end
    rem_day_d = 17'(sat - 20'(wd_d) * 20'(gwc_pkg::SecsPerDay));
  end

  // stage 2: hour by reciprocal multiply
  assign hr_prod = 35'(rem_day_q1) * 35'(gwc_pkg::HourRecip);
  assign hr_d    = 5'(hr_prod >> gwc_pkg::HourShift);

  // stage 3: seconds into the hour
  assign rem_hr_d = 12'(rem_day_q2 - 17'(hr_q2) * 17'(gwc_pkg::SecsPerHour));

  // stage 4: minute by reciprocal multiply
  assign mn_prod = 24'(rem_hr_q3) * 24'(gwc_pkg::MinRecip);
  assign mn_d    = 6'(mn_prod >> gwc_pkg::MinShift);

  // stage 5: seconds into the minute
  assign sc_d = 6'(rem_hr_q4 - 12'(mn_q4) * 12'(gwc_pkg::SecsPerMin));

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      wd_q1      <= wd_d;
      rem_day_q1 <= rem_day_d;
    end
    if (en_i[1]) begin
      wd_q2      <= wd_q1;
      rem_day_q2 <= rem_day_q1;
      hr_q2      <= hr_d;
    end
    if (en_i[2]) begin
      wd_q3     <= wd_q2;
      hr_q3     <= hr_q2;
      rem_hr_q3 <= rem_hr_d;
    end
    if (en_i[3]) begin
      wd_q4     <= wd_q3;
      hr_q4     <= hr_q3;
      rem_hr_q4 <= rem_hr_q3;
      mn_q4     <= mn_d;
    end
    if (en_i[4]) begin
      wd_q5 <= wd_q4;
      hr_q5 <= hr_q4;
      mn_q5 <= mn_q4;
      sc_q5 <= sc_d;
    end
  end

  assign wd_s4_o   = wd_q4;
  assign weekday_o = wd_q5;
  assign hour_o    = hr_q5;
  assign minute_o  = mn_q5;
  assign second_o  = sc_q5;

endmodule

// ===== hw/rtl/gwc_date_pipe.sv =====
// gwc_date_pipe: five-stage conversion of gps week plus weekday to year, month, day
// depends on gwc_pkg; stage enables and the stage-4 weekday come from the top level
module gwc_date_pipe (
  input  logic                            clk_i,
  input  logic [gwc_pkg::NumStages-1:0]   en_i,
  input  logic [gwc_pkg::WeekW-1:0]       week_i,
  input  logic [gwc_pkg::WdW-1:0]         wd_s4_i,
  output logic [gwc_pkg::YearW-1:0]       year_o,
  output logic [gwc_pkg::MonthW-1:0]      month_o,
  output logic [gwc_pkg::DayW-1:0]        day_o
);

  logic                        wk0_d;
  logic [15:0]                 dm1_d;
  logic [31:0]                 blk_prod;
  logic [5:0]                  blk_d;
  logic [15:0]                 r_wide;
  logic [10:0]                 r_d;
  logic [1:0]                  x;
  logic [8:0]                  doy_d;
  logic [gwc_pkg::YearW-1:0]   year_d;
  logic [8:0]                  cum_lo, cum_hi;
  logic [gwc_pkg::MonthW-1:0]  m;
  logic [5:0]                  day_t, len;
  logic [gwc_pkg::YearW-1:0]   year5_d;
  logic [gwc_pkg::MonthW-1:0]  month5_d;
  logic [gwc_pkg::DayW-1:0]    day5_d;

  logic                        wk0_q1, wk0_q2, wk0_q3, wk0_q4;
  logic [15:0]                 dm1_q1, dm1_q2;
  logic [5:0]                  blk_q2, blk_q3;
  logic [10:0]                 r_q3;
  logic [8:0]                  doy_q4;
  logic                        leap_q4;
  logic [gwc_pkg::YearW-1:0]   year_q4, year_q5;
  logic [gwc_pkg::MonthW-1:0]  month_q5;
  logic [gwc_pkg::DayW-1:0]    day_q5;

  // stage 1: day count minus one (don't care for week zero)
  assign wk0_d = (week_i == '0);
  assign dm1_d = 16'(week_i) * 16'(gwc_pkg::DaysPerWeek) - 16'd1;

  // stage 2: four-year block by reciprocal multiply
  assign blk_prod = 32'(dm1_q1) * 32'(gwc_pkg::BlkRecip);
  assign blk_d    = 6'(blk_prod >> gwc_pkg::BlkShift);

  // stage 3: day within the block, 1..1461, so a boundary lands on 31 december
  assign r_wide = dm1_q2 + 16'd1 - 16'(blk_q2) * 16'(gwc_pkg::DaysPerBlock);
  assign r_d    = 11'(r_wide);

  // stage 4: year inside the block and one-based day of year
  always_comb begin
    x = '0;
    for (int k = 1; k < 4; k++) begin
      if (r_q3 > gwc_pkg::BlockStart[2'(k)]) begin
        x = 2'(k);
      end
    end
    doy_d  = 9'(r_q3 - gwc_pkg::BlockStart[x]);
    year_d = gwc_pkg::EpochYear + 12'({blk_q3, 2'b00}) + 12'(x);
  end

  // stage 5: month search, add epoch offset and weekday, one month carry
  always_comb begin
    m = '0;
    for (int i = 0; i < 11; i++) begin
      if (doy_q4 > (leap_q4 ? gwc_pkg::CumLeap[4'(i+1)] : gwc_pkg::CumNormal[4'(i+1)])) begin
        m = 4'(i + 1);
      end
    end
    cum_lo = leap_q4 ? gwc_pkg::CumLeap[m] : gwc_pkg::CumNormal[m];
    cum_hi = leap_q4 ? gwc_pkg::CumLeap[4'(m + 4'd1)] : gwc_pkg::CumNormal[4'(m + 4'd1)];
    day_t  = 6'(doy_q4 - cum_lo) + gwc_pkg::EpochDay + 6'(wd_s4_i);
    len    = 6'(cum_hi - cum_lo);
    year5_d = year_q4;
    if (day_t > len) begin
      day_t = day_t - len;
      m     = m + 4'd1;
    end
    // december rolls into january of the next year
    if (m >= gwc_pkg::MonthWrap) begin
      m       = '0;
      year5_d = year_q4 + 12'd1;
    end
    month5_d = m;
    day5_d   = 5'(day_t);
    if (wk0_q4) begin
      year5_d  = gwc_pkg::EpochYear;
      month5_d = '0;
      day5_d   = 5'(gwc_pkg::EpochDay + 6'(wd_s4_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      wk0_q1 <= wk0_d;
      dm1_q1 <= dm1_d;
    end
    if (en_i[1]) begin
      wk0_q2 <= wk0_q1;
      dm1_q2 <= dm1_q1;
      blk_q2 <= blk_d;
    end
    if (en_i[2]) begin
      wk0_q3 <= wk0_q2;
      blk_q3 <= blk_q2;
      r_q3   <= r_d;
    end
    if (en_i[3]) begin
      wk0_q4  <= wk0_q3;
      doy_q4  <= doy_d;
      leap_q4 <= (x == 2'd0);
      year_q4 <= year_d;
    end
    if (en_i[4]) begin
      year_q5  <= year5_d;
      month_q5 <= month5_d;
      day_q5   <= day5_d;
    end
  end

  assign year_o  = year_q5;
  assign month_o = month_q5;
  assign day_o   = day_q5;

endmodule

// ===== hw/rtl/gps_week_to_calendar_date.sv =====
// gps_week_to_calendar_date: top level, valid bits and stall control over two data pipes
// depends on gwc_pkg, gwc_in_if, gwc_out_if, gwc_tod_pipe and gwc_date_pipe
//
// Converts a gps week number and seconds of week into calendar year, month, day and
// time of day, counted from 6 january 1980. Seconds of week above the last second of
// the week saturate to it. The block takes one transfer per cycle unless a stall holds
// the pipeline, and it holds five register stages; the divisions by constants are
// reciprocal multiplies, each followed by a register, and the stage count follows
// from those multiplies and the month search. Every stage has its own valid bit and
// only a full stage whose successor is blocked holds, so the pipeline keeps accepting
// transfers while bubbles remain, and a stalled result is held in the output register
// until it is taken.
module gps_week_to_calendar_date (
  input  logic       clk_i,
  input  logic       rst_ni,
  gwc_in_if.sink     in_i,
  gwc_out_if.source  out_o
);

  logic [gwc_pkg::NumStages-1:0] v_q;
  logic [gwc_pkg::NumStages-1:0] en;
  logic [gwc_pkg::WdW-1:0]       wd_s4;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[gwc_pkg::NumStages-1] = !v_q[gwc_pkg::NumStages-1] || out_o.ready;
    for (int k = int'(gwc_pkg::NumStages) - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < int'(gwc_pkg::NumStages); k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = v_q[gwc_pkg::NumStages-1];

  gwc_tod_pipe u_tod (
    .clk_i     (clk_i),
    .en_i      (en),
    .secs_i    (in_i.seconds_of_week),
    .wd_s4_o   (wd_s4),
    .weekday_o (out_o.weekday),
    .hour_o    (out_o.hour_of_day),
    .minute_o  (out_o.minute_of_hour),
    .second_o  (out_o.second_of_minute)
  );

  gwc_date_pipe u_date (
    .clk_i   (clk_i),
    .en_i    (en),
    .week_i  (in_i.gps_week),
    .wd_s4_i (wd_s4),
    .year_o  (out_o.year),
    .month_o (out_o.month_index),
    .day_o   (out_o.day_of_month)
  );

endmodule
